// ===== design/tbti_pkg.sv =====
// ----------------------------------------------------------------------------
// tbti_pkg: timebase and timer interrupt shared definitions
// Widths, register indexes, source codes, flag bits and inter-module types.
// ----------------------------------------------------------------------------
package tbti_pkg;

  localparam int unsigned TickW   = 14;
  localparam int unsigned CountW  = 16;
  localparam int unsigned FlagW   = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TB_SEL   = 3'd0,
    REG_A_SOURCE = 3'd1,
    REG_A_ENABLE = 3'd2,
    REG_A_RELOAD = 3'd3,
    REG_B_SOURCE = 3'd4,
    REG_B_ENABLE = 3'd5,
    REG_B_RELOAD = 3'd6
  } tbti_reg_e;

  // fast source codes shared by timers A and B; SRC_A_SLOW is for timer A only
  localparam logic [2:0] SRC_EVERY   = 3'd2;
  localparam logic [2:0] SRC_EVERY4  = 3'd3;
  localparam logic [2:0] SRC_EVERY8  = 3'd4;
  localparam logic [2:0] SRC_A_SLOW  = 3'd5;

  // slow source codes of timer A
  localparam logic [2:0] SLOW_2048   = 3'd0;
  localparam logic [2:0] SLOW_1024   = 3'd1;
  localparam logic [2:0] SLOW_256    = 3'd2;
  localparam logic [2:0] SLOW_TB1    = 3'd3;
  localparam logic [2:0] SLOW_4      = 3'd4;
  localparam logic [2:0] SLOW_2      = 3'd5;

  localparam logic [FlagW-1:0] FLAG_A      = 12'h800;
  localparam logic [FlagW-1:0] FLAG_B      = 12'h400;
  localparam logic [FlagW-1:0] FLAG_4096   = 12'h040;
  localparam logic [FlagW-1:0] FLAG_2048   = 12'h020;
  localparam logic [FlagW-1:0] FLAG_1024   = 12'h010;
  localparam logic [FlagW-1:0] FLAG_4      = 12'h008;
  localparam logic [FlagW-1:0] FLAG_TB2    = 12'h002;
  localparam logic [FlagW-1:0] FLAG_TB1    = 12'h001;

  typedef struct packed {
    logic [3:0] timebase_select;
    logic [5:0] timer_a_source;
    logic       timer_a_enable;
    logic [2:0] timer_b_source;
    logic       timer_b_enable;
  } tbti_ctrl_t;

  typedef struct packed {
    logic [FlagW-1:0] base_flags;
    logic             a_step;
    logic             b_step;
  } tbti_rate_t;

endpackage

// ===== design/tbti_if.sv =====
// ----------------------------------------------------------------------------
// tbti_if: channel interfaces
// Input tick channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface tbti_in_if;
  logic valid;
  logic ready;
  logic clear_ticks;

  modport source (output valid, output clear_ticks, input ready);
  modport sink   (input valid, input clear_ticks, output ready);
endinterface

interface tbti_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbti_pkg::FlagW-1:0]   irq_flags;
  logic [tbti_pkg::CountW-1:0]  timer_a_value;
  logic [tbti_pkg::CountW-1:0]  timer_b_value;

  modport source (output valid, output irq_flags, output timer_a_value,
                  output timer_b_value, input ready);
  modport sink   (input valid, input irq_flags, input timer_a_value,
                  input timer_b_value, output ready);
endinterface

interface tbti_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tbti_pkg::CfgIdxW-1:0]  index;
  logic [tbti_pkg::CfgDatW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/tbti_rate.sv =====
// ----------------------------------------------------------------------------
// tbti_rate: rate decode
// Compare the advanced tick count with the timebase and timer source masks.
// ----------------------------------------------------------------------------
module tbti_rate (
  input  logic [tbti_pkg::TickW-1:0] ticks,
  input  tbti_pkg::tbti_ctrl_t       ctrl,
  output tbti_pkg::tbti_rate_t       rate
);

  logic [12:0]                 tb1_span;
  logic [8:0]                  tb2_span;
  logic [tbti_pkg::TickW-1:0]  tb1_mask;
  logic [tbti_pkg::TickW-1:0]  tb2_mask;
  logic [tbti_pkg::TickW-1:0]  a_mask;
  logic [tbti_pkg::TickW-1:0]  b_mask;
  logic                        a_run;
  logic                        b_run;
  logic [tbti_pkg::FlagW-1:0]  flags;

  assign tb1_span = 13'd4096 >> ctrl.timebase_select[1:0];
  assign tb2_span = 9'd256 >> ctrl.timebase_select[3:2];
  assign tb1_mask = tbti_pkg::TickW'(tb1_span - 13'd1);
  assign tb2_mask = tbti_pkg::TickW'(tb2_span - 9'd1);

  always_comb begin
    a_run  = 1'b1;
    a_mask = '0;
    unique case (ctrl.timer_a_source[2:0])
      tbti_pkg::SRC_EVERY:  a_mask = 14'd0;
      tbti_pkg::SRC_EVERY4: a_mask = 14'd3;
      tbti_pkg::SRC_EVERY8: a_mask = 14'd7;
      tbti_pkg::SRC_A_SLOW: begin
        unique case (ctrl.timer_a_source[5:3])
          tbti_pkg::SLOW_2048: a_mask = 14'd15;
          tbti_pkg::SLOW_1024: a_mask = 14'd31;
          tbti_pkg::SLOW_256:  a_mask = 14'd127;
          tbti_pkg::SLOW_TB1:  a_mask = tb1_mask;
          tbti_pkg::SLOW_4:    a_mask = 14'd8191;
          tbti_pkg::SLOW_2:    a_mask = 14'd16383;
          default:             a_run  = 1'b0;
        endcase
      end
      default: a_run = 1'b0;
    endcase
  end

  always_comb begin
    b_run  = 1'b1;
    b_mask = '0;
    unique case (ctrl.timer_b_source)
      tbti_pkg::SRC_EVERY:  b_mask = 14'd0;
      tbti_pkg::SRC_EVERY4: b_mask = 14'd3;
      tbti_pkg::SRC_EVERY8: b_mask = 14'd7;
      default:              b_run  = 1'b0;
    endcase
  end

  always_comb begin
    flags = '0;
    if ((ticks & 14'd7) == '0)    flags = flags | tbti_pkg::FLAG_4096;
    if ((ticks & 14'd15) == '0)   flags = flags | tbti_pkg::FLAG_2048;
    if ((ticks & 14'd31) == '0)   flags = flags | tbti_pkg::FLAG_1024;
    if ((ticks & 14'd8191) == '0) flags = flags | tbti_pkg::FLAG_4;
    if ((ticks & tb1_mask) == '0) flags = flags | tbti_pkg::FLAG_TB1;
    if ((ticks & tb2_mask) == '0) flags = flags | tbti_pkg::FLAG_TB2;
  end

  assign rate.base_flags = flags;
  assign rate.a_step     = ctrl.timer_a_enable & a_run & ((ticks & a_mask) == '0);
  assign rate.b_step     = ctrl.timer_b_enable & b_run & ((ticks & b_mask) == '0);

endmodule

// ===== design/tbti_timer.sv =====
// ----------------------------------------------------------------------------
// tbti_timer: 16-bit up-counter with reload
// Count on step, reload and flag on wrap to zero, load on register write.
// ----------------------------------------------------------------------------
module tbti_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [tbti_pkg::CountW-1:0] load_value,
  input  logic                        step,
  output logic [tbti_pkg::CountW-1:0] count_next,
  output logic                        wrap
);

  logic [tbti_pkg::CountW-1:0] count;
  logic [tbti_pkg::CountW-1:0] reload;
  logic [tbti_pkg::CountW-1:0] count_inc;

  assign count_inc = count + tbti_pkg::CountW'(1);
  assign wrap      = step & (count_inc == '0);

  always_comb begin
    count_next = count;
    if (step) begin
      count_next = wrap ? reload : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      reload <= '0;
    end else if (load) begin
      count  <= load_value;
      reload <= load_value;
    end else begin
      count  <= count_next;
    end
  end

endmodule

// ===== design/timebase_and_timer_irq.sv =====
// ----------------------------------------------------------------------------
// timebase_and_timer_irq: timebase flags and two reloadable timers
//
//   channel  dir  beat payload
//   in_ch    in   clear_ticks
//   out_ch   out  irq_flags, timer_a_value, timer_b_value
//   cfg      in   index, data (register write, always ready)
//
// One item per cycle unless the result stalls; input, then result register.
// The input register feeds one pass of mask compare and 16-bit increment that
// lands in the result register together with the tick and timer state.
// Synchronous reset clears control, valid flags, counts and the tick counter.
// A stalled result holds; the input register still takes a beat while the
// result register is being drained in the same cycle.
// ----------------------------------------------------------------------------
module timebase_and_timer_irq (
  input  logic              clk,
  input  logic              rst,
  tbti_in_if.sink           in_ch,
  tbti_out_if.source        out_ch,
  tbti_cfg_if.sink          cfg
);

  tbti_pkg::tbti_ctrl_t          ctrl;
  tbti_pkg::tbti_rate_t          rate;
  logic [tbti_pkg::TickW-1:0]    base_ticks;
  logic [tbti_pkg::TickW-1:0]    ticks_inc;
  logic                          s1_valid;
  logic                          s1_clear;
  logic                          advance;
  logic                          tick;
  logic                          cfg_we;
  logic                          load_a;
  logic                          load_b;
  logic [tbti_pkg::CountW-1:0]   count_a_next;
  logic [tbti_pkg::CountW-1:0]   count_b_next;
  logic                          wrap_a;
  logic                          wrap_b;
  logic [tbti_pkg::FlagW-1:0]    flags_next;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid & cfg.ready;
  assign load_a    = cfg_we & (cfg.index == tbti_pkg::REG_A_RELOAD);
  assign load_b    = cfg_we & (cfg.index == tbti_pkg::REG_B_RELOAD);

  assign advance     = s1_valid & (~out_ch.valid | out_ch.ready);
  assign in_ch.ready = ~s1_valid | advance;
  assign tick        = advance & ~s1_clear;
  assign ticks_inc   = base_ticks + tbti_pkg::TickW'(1);

  tbti_rate u_rate (
    .ticks (ticks_inc),
    .ctrl  (ctrl),
    .rate  (rate)
  );

  tbti_timer u_timer_a (
    .clk        (clk),
    .rst        (rst),
    .load       (load_a),
    .load_value (cfg.data),
    .step       (tick & rate.a_step),
    .count_next (count_a_next),
    .wrap       (wrap_a)
  );

  tbti_timer u_timer_b (
    .clk        (clk),
    .rst        (rst),
    .load       (load_b),
    .load_value (cfg.data),
    .step       (tick & rate.b_step),
    .count_next (count_b_next),
    .wrap       (wrap_b)
  );

  always_comb begin
    flags_next = '0;
    if (!s1_clear) begin
      flags_next = rate.base_flags;
      if (wrap_a) flags_next = flags_next | tbti_pkg::FLAG_A;
      if (wrap_b) flags_next = flags_next | tbti_pkg::FLAG_B;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (cfg_we) begin
      unique case (cfg.index)
        tbti_pkg::REG_TB_SEL:   ctrl.timebase_select <= cfg.data[3:0];
        tbti_pkg::REG_A_SOURCE: ctrl.timer_a_source  <= cfg.data[5:0];
        tbti_pkg::REG_A_ENABLE: ctrl.timer_a_enable  <= cfg.data[0];
        tbti_pkg::REG_B_SOURCE: ctrl.timer_b_source  <= cfg.data[2:0];
        tbti_pkg::REG_B_ENABLE: ctrl.timer_b_enable  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_clear <= in_ch.clear_ticks;
    end
  end

  // tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      base_ticks <= '0;
    end else if (advance) begin
      base_ticks <= s1_clear ? '0 : ticks_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.irq_flags     <= flags_next;
      out_ch.timer_a_value <= count_a_next;
      out_ch.timer_b_value <= count_b_next;
    end
  end

endmodule
